// File: hdl/pkbct_pkg.sv
// Shared types and constants for the per-key byte counter table.
// Depends on nothing; imported by the top level of the table.
package pkbct_pkg;

    localparam int KEY_W    = 22;
    localparam int CNT_W    = 31;
    localparam int RIDX_W   = 10;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int TOT_W    = 64;
    localparam int MOD_W    = 11;
    localparam int SLOT_O_W = 10;

    localparam logic [MOD_W-1:0] MOD_RESET = 11'd1024;

    // Input word layout, lowest bits first: key, count, read index, zero fill.
    localparam int S_TDATA_W = 64;
    // Output word layout, lowest bits first: slot, owner, rx total, tx total.
    localparam int M_TDATA_W = 160;

    localparam logic [OP_W-1:0] OP_COUNT_TX = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT_RX = 2'd1;
    localparam logic [OP_W-1:0] OP_READ     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_COUNTED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_COLLIDED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_READ     = 2'd3;

    // One table slot as stored in the RAM.
    typedef struct packed {
        logic [TOT_W-1:0] tx_total;
        logic [TOT_W-1:0] rx_total;
        logic [KEY_W-1:0] owner_key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hdl/pkbct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the slot store of the counter table.
module pkbct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/per_key_byte_counter_table.sv
// Top level of the per-key byte counter table: control, divider and output register.
// Depends on pkbct_pkg and pkbct_ram.
//
// A count word (opcode 0 for sent bytes, 1 for received bytes) carries a process key
// and a byte count. The key is reduced modulo the configured slot count by a restoring
// divider that retires one quotient bit per cycle. A count word passes through an
// accept step, the divide steps, a RAM read step and an update step before the next
// word is accepted. A read word (opcode 2 or 3) skips the divider. The slot lives in
// one RAM with a registered read; the update cycle modifies the entry and writes it
// back, and since only one word is in flight no forwarding is needed. After reset a
// clearing pass, during which no word is accepted, writes every one of the SLOTS
// entries to zero. Each word yields exactly one result word, held in an output
// register, so the next word may be accepted while the previous result waits to be
// taken. A slot count of zero acts as one, and a count above SLOTS acts as SLOTS.
// The slot count is to be changed only while the block idles.
module per_key_byte_counter_table #(
    parameter int SLOTS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: slot count in use.
    input  logic                              cfg_wr_en,
    input  logic [pkbct_pkg::MOD_W-1:0]       cfg_wr_data,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: process_key[21:0], byte_count[52:22], read_index[62:53],
    // zero fill[63].
    input  logic [pkbct_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [pkbct_pkg::OP_W-1:0]        s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: slot_used[9:0], owner_key[31:10], rx_total[95:32],
    // tx_total[159:96].
    output logic [pkbct_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: status[1:0].
    output logic [pkbct_pkg::STAT_W-1:0]      m_tuser
);

    import pkbct_pkg::*;

    localparam int SIDX = $clog2(SLOTS);
    localparam int DIV_CNT_W = $clog2(KEY_W);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SIDX-1:0]       clr_addr_reg, clr_addr_next;
    logic [MOD_W-1:0]      slots_reg;
    logic [MOD_W-1:0]      mod_eff;

    // Word in flight.
    logic                  is_read_reg, is_read_next;
    logic                  is_rx_reg, is_rx_next;
    logic                  idx_ok_reg, idx_ok_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SIDX-1:0]       slot_reg, slot_next;
    logic [SLOT_O_W-1:0]   slot_out_reg, slot_out_next;

    // Divider.
    logic [KEY_W-1:0]      quot_reg, quot_next;
    logic [MOD_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [MOD_W:0]        trial;
    logic [MOD_W:0]        mod_ext;
    logic [MOD_W:0]        rem_step;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]     m_tuser_reg, m_tuser_next;

    // RAM side.
    logic                  ram_we;
    logic [SIDX-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                cur_entry;
    entry_t                new_entry;
    entry_t                shown_entry;
    logic [STAT_W-1:0]     res_status;
    logic                  do_write;
    logic                  out_ok;
    logic                  out_load;
    logic                  s_accept;
    logic [S_TDATA_W-1:0]  in_word;

    pkbct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // The modulus actually used: zero behaves as one, oversize clamps to the store size.
    always_comb begin
        if (slots_reg == '0) begin
            mod_eff = MOD_W'(1);
        end else if (32'(slots_reg) > SLOTS) begin
            mod_eff = MOD_W'(SLOTS);
        end else begin
            mod_eff = slots_reg;
        end
    end

    // One restoring division step: bring down the next key bit, subtract if it fits.
    assign mod_ext  = {1'b0, mod_eff};
    assign trial    = {rem_reg, quot_reg[KEY_W-1]};
    assign rem_step = (trial >= mod_ext) ? (trial - mod_ext) : trial;

    assign in_word  = s_tdata;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_ok   = !m_tvalid_reg || m_tready;

    // Read-modify-write of the slot, evaluated while the read data is on the RAM port.
    assign cur_entry = entry_t'(ram_rdata);

    always_comb begin
        new_entry   = cur_entry;
        shown_entry = cur_entry;
        do_write    = 1'b0;
        if (is_read_reg) begin
            res_status = STAT_READ;
            if (!idx_ok_reg) begin
                shown_entry = '0;
            end
        end else if (key_reg == '0 || cnt_reg == '0) begin
            res_status = STAT_IGNORED;
        end else if (cur_entry.owner_key != '0 && cur_entry.owner_key != key_reg) begin
            res_status = STAT_COLLIDED;
        end else begin
            res_status          = STAT_COUNTED;
            do_write            = 1'b1;
            new_entry.owner_key = key_reg;
            if (is_rx_reg) begin
                new_entry.rx_total = cur_entry.rx_total + TOT_W'(cnt_reg);
            end else begin
                new_entry.tx_total = cur_entry.tx_total + TOT_W'(cnt_reg);
            end
            shown_entry = new_entry;
        end
    end

    assign out_load = (state_reg == ST_DONE) && out_ok;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = ENTRY_W'(new_entry);
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (out_load && do_write) begin
            ram_we = 1'b1;
        end
    end

    // Main sequencer.
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        is_read_next  = is_read_reg;
        is_rx_next    = is_rx_reg;
        idx_ok_next   = idx_ok_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        slot_out_next = slot_out_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + SIDX'(1);
                if (clr_addr_reg == SIDX'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    key_next     = in_word[KEY_W-1:0];
                    cnt_next     = in_word[KEY_W +: CNT_W];
                    is_rx_next   = (s_tuser == OP_COUNT_RX);
                    is_read_next = (s_tuser == OP_READ) || (s_tuser[1] == 1'b1);
                    if (is_read_next) begin
                        slot_out_next = in_word[KEY_W+CNT_W +: RIDX_W];
                        slot_next     = SIDX'(slot_out_next);
                        idx_ok_next   = (32'(slot_out_next) < SLOTS);
                        state_next    = ST_READ;
                    end else begin
                        quot_next    = key_next;
                        rem_next     = '0;
                        div_cnt_next = DIV_CNT_W'(KEY_W - 1);
                        idx_ok_next  = 1'b1;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next     = rem_step[MOD_W-1:0];
                quot_next    = {quot_reg[KEY_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0) begin
                    slot_next     = SIDX'(rem_step[MOD_W-1:0]);
                    slot_out_next = SLOT_O_W'(rem_step[MOD_W-1:0]);
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = res_status;
            m_tdata_next  = {shown_entry.tx_total, shown_entry.rx_total,
                             shown_entry.owner_key, slot_out_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            slots_reg    <= MOD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                slots_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        is_read_reg  <= is_read_next;
        is_rx_reg    <= is_rx_next;
        idx_ok_reg   <= idx_ok_next;
        key_reg      <= key_next;
        cnt_reg      <= cnt_next;
        slot_reg     <= slot_next;
        slot_out_reg <= slot_out_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The partial remainder never reaches the modulus while dividing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < mod_ext))
        else $error("divider remainder not below modulus");

    // The store is written only by the clearing pass or by the update cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_DONE))
        else $error("store written outside clear or update");

    // A counted result always shows the counting key as the slot owner.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_status == STAT_COUNTED) |=>
            (m_tdata[SLOT_O_W +: KEY_W] == $past(key_reg)))
        else $error("counted result shows wrong owner");

    // An accepted word leaves idle at once, so no second word slips in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second word accepted while one is in flight");

endmodule
